@@ rtl/core/itf_pkg.sv @@
// ----------------------------------------------------------------------------
// itf_pkg
// Types, codes and constants shared by the integer-to-text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

	// Longest binary field and number of decimal digit cells.
	localparam int MAX_WIDTH  = 32;
	localparam int DEC_DIGITS = 10;

	// Counter wide enough for MAX_WIDTH, for the bit count 31 and for the 6-bit width field.
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CNTW = (WW > 6) ? WW : 6;
	localparam int NW   = $clog2(DEC_DIGITS + 1);

	// Base selector codes; the unused code renders as hexadecimal.
	localparam logic [1:0] KIND_BIN = 2'd0;
	localparam logic [1:0] KIND_DEC = 2'd1;
	localparam logic [1:0] KIND_HEX = 2'd2;

	// ASCII constants.
	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_SPACE   = 7'h20;
	localparam logic [6:0] CH_HEX_OFS = 7'h57;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  kind;
		logic [5:0]  width;
	} item_t;

	typedef struct packed {
		logic [6:0] character;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_DABBLE,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     bit_in;
	} chain_ctl_t;

	typedef struct packed {
		logic [3:0] top_digit;
		logic       carry;
	} chain_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_PAD,
		ST_DEC,
		ST_BIN,
		ST_HEX
	} state_t;

endpackage

@@ rtl/core/itf_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// itf_bcd_cell
// One decimal digit of the conversion chain: shift-and-add-3 step, digit move, clear or hold.
module itf_bcd_cell (
	input  logic              clk,
	input  itf_pkg::cell_op_t op,
	input  logic              bit_in,
	input  logic [3:0]        digit_in,
	output logic [3:0]        digit,
	output logic              carry_out
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Digits of five or more get three added so that the doubling carries in decimal.
	always_comb begin
		adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
		carry_out = adj[3];
	end

	always_ff @(posedge clk) begin
		unique case (op)
			itf_pkg::OP_HOLD:   digit_q <= digit_q;
			itf_pkg::OP_CLEAR:  digit_q <= 4'd0;
			itf_pkg::OP_DABBLE: digit_q <= {adj[2:0], bit_in};
			itf_pkg::OP_SHIFT:  digit_q <= digit_in;
		endcase
	end

	assign digit = digit_q;

endmodule

@@ rtl/core/itf_bcd_chain.sv @@
// ----------------------------------------------------------------------------
// itf_bcd_chain
// Row of digit cells; bits enter at the low end, digits leave at the high end.
// ----------------------------------------------------------------------------
module itf_bcd_chain (
	input  logic                clk,
	input  itf_pkg::chain_ctl_t ctl,
	output itf_pkg::chain_sts_t sts
);

	logic [3:0] digit [itf_pkg::DEC_DIGITS];
	logic       carry [itf_pkg::DEC_DIGITS];

	for (genvar i = 0; i < itf_pkg::DEC_DIGITS; i++) begin : g_cell
		logic       bit_in;
		logic [3:0] digit_in;

		if (i == 0) begin : g_low
			assign bit_in   = ctl.bit_in;
			assign digit_in = 4'd0;
		end else begin : g_mid
			assign bit_in   = carry[i-1];
			assign digit_in = digit[i-1];
		end

		itf_bcd_cell u_cell (
			.clk       (clk),
			.op        (ctl.op),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.digit     (digit[i]),
			.carry_out (carry[i])
		);
	end

	// A carry out of the top cell means the value has more digits than the row keeps.
	assign sts.top_digit = digit[itf_pkg::DEC_DIGITS-1];
	assign sts.carry     = carry[itf_pkg::DEC_DIGITS-1];

endmodule

@@ rtl/core/integer_to_text_formatter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_formatter_top
// Renders a 32-bit unsigned value as binary, decimal or hex ASCII, one
// character per cycle.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   input    | start / busy         | item   : value, kind, width
//   output   | strobe (one cycle)   | result : character, last
//
// Binary and hex items stay busy while sending; hex gives at most 8 digits.
// Decimal items first run through the BCD cell chain (one value bit per
// cycle), then suppress leading zeros, keeping at least one digit, then
// send max(width, digit count) characters, spaces first, one per cycle.
// Reset clears the controller only. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  itf_pkg::item_t   item,
	output logic             strobe,
	output itf_pkg::result_t result
);

	localparam int CNTW = itf_pkg::CNTW;
	localparam int NW   = itf_pkg::NW;

	itf_pkg::state_t     state_q, state_d;
	logic [31:0]         value_q, value_d;
	logic [CNTW-1:0]     cnt_q, cnt_d;
	logic [CNTW-1:0]     width_q, width_d;
	logic [NW-1:0]       nd_q, nd_d;
	logic                ovf_q, ovf_d;
	itf_pkg::chain_ctl_t ctl;
	itf_pkg::chain_sts_t sts;

	logic [CNTW-1:0] w_ext, w_clip, w_hex, nd_ext, pad;
	logic [3:0]      nib;
	logic            bin_bit;

	itf_bcd_chain u_chain (
		.clk (clk),
		.ctl (ctl),
		.sts (sts)
	);

	always_comb begin
		w_ext   = CNTW'(item.width);
		w_clip  = (w_ext > CNTW'(itf_pkg::MAX_WIDTH)) ? CNTW'(itf_pkg::MAX_WIDTH) : w_ext;
		w_hex   = (w_clip > CNTW'(8)) ? CNTW'(8) : w_clip;
		nd_ext  = CNTW'(nd_q);
		pad     = (width_q > nd_ext) ? width_q - nd_ext : '0;
		nib     = value_q[{cnt_q[2:0], 2'b00} +: 4];
		bin_bit = (cnt_q < CNTW'(32)) ? value_q[cnt_q[4:0]] : 1'b0;
	end

	always_comb begin
		state_d    = state_q;
		value_d    = value_q;
		cnt_d      = cnt_q;
		width_d    = width_q;
		nd_d       = nd_q;
		ovf_d      = ovf_q;
		ctl.op     = itf_pkg::OP_HOLD;
		ctl.bit_in = value_q[31];
		strobe     = 1'b0;
		result     = '{character: itf_pkg::CH_SPACE, last: 1'b0};

		unique case (state_q)
			itf_pkg::ST_IDLE: begin
				if (start) begin
					value_d = item.value;
					width_d = w_clip;
					ovf_d   = 1'b0;
					unique case (item.kind)
						itf_pkg::KIND_BIN: begin
							cnt_d   = w_clip - CNTW'(1);
							state_d = (w_clip == '0) ? itf_pkg::ST_IDLE : itf_pkg::ST_BIN;
						end
						itf_pkg::KIND_DEC: begin
							ctl.op  = itf_pkg::OP_CLEAR;
							cnt_d   = CNTW'(31);
							state_d = itf_pkg::ST_CONV;
						end
						default: begin
							cnt_d   = w_hex - CNTW'(1);
							state_d = (w_hex == '0) ? itf_pkg::ST_IDLE : itf_pkg::ST_HEX;
						end
					endcase
				end
			end
			itf_pkg::ST_CONV: begin
				ctl.op  = itf_pkg::OP_DABBLE;
				value_d = {value_q[30:0], 1'b0};
				ovf_d   = ovf_q | sts.carry;
				cnt_d   = cnt_q - CNTW'(1);
				if (cnt_q == '0) begin
					nd_d    = NW'(itf_pkg::DEC_DIGITS);
					state_d = itf_pkg::ST_SKIP;
				end
			end
			itf_pkg::ST_SKIP: begin
				// Drop leading zeros one per cycle unless the value overflowed the row.
				if (!ovf_q && sts.top_digit == 4'd0 && nd_q > NW'(1)) begin
					ctl.op = itf_pkg::OP_SHIFT;
					nd_d   = nd_q - NW'(1);
				end else begin
					cnt_d   = pad;
					state_d = (pad == '0) ? itf_pkg::ST_DEC : itf_pkg::ST_PAD;
				end
			end
			itf_pkg::ST_PAD: begin
				strobe = 1'b1;
				cnt_d  = cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					state_d = itf_pkg::ST_DEC;
				end
			end
			itf_pkg::ST_DEC: begin
				strobe           = 1'b1;
				result.character = itf_pkg::CH_ZERO + 7'(sts.top_digit);
				result.last      = (nd_q == NW'(1));
				ctl.op           = itf_pkg::OP_SHIFT;
				nd_d             = nd_q - NW'(1);
				if (nd_q == NW'(1)) begin
					state_d = itf_pkg::ST_IDLE;
				end
			end
			itf_pkg::ST_BIN: begin
				strobe           = 1'b1;
				result.character = itf_pkg::CH_ZERO + 7'(bin_bit);
				result.last      = (cnt_q == '0);
				cnt_d            = cnt_q - CNTW'(1);
				if (cnt_q == '0) begin
					state_d = itf_pkg::ST_IDLE;
				end
			end
			itf_pkg::ST_HEX: begin
				strobe           = 1'b1;
				result.character = (nib >= 4'd10) ? itf_pkg::CH_HEX_OFS + 7'(nib)
				                                  : itf_pkg::CH_ZERO + 7'(nib);
				result.last      = (cnt_q == '0);
				cnt_d            = cnt_q - CNTW'(1);
				if (cnt_q == '0) begin
					state_d = itf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		cnt_q   <= cnt_d;
		width_q <= width_d;
		nd_q    <= nd_d;
		ovf_q   <= ovf_d;
	end

	assign busy = (state_q != itf_pkg::ST_IDLE);

endmodule

@@ rtl/core/itf_checker.sv @@
// ----------------------------------------------------------------------------
// itf_checker
// Port-level checks of the formatter's transaction sequencing.
// ----------------------------------------------------------------------------
module itf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input itf_pkg::item_t   item,
	input logic             strobe,
	input itf_pkg::result_t result
);

	// Characters only appear inside a transaction.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("character strobed while not busy");

	// The final character ends the transaction.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe && !busy)
		else $error("activity after the last character");

	// A character that is not the last is followed by more work.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> busy)
		else $error("transaction dropped before its last character");

	// Binary with zero width produces nothing.
	a_bin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == itf_pkg::KIND_BIN && item.width == 6'd0 |=> !busy)
		else $error("zero-width binary item did not finish at once");

	// Decimal conversion runs before the first character.
	a_dec_conv: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == itf_pkg::KIND_DEC |=> busy && !strobe)
		else $error("decimal item strobed before conversion");

endmodule

bind integer_to_text_formatter_top itf_checker u_itf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.strobe (strobe),
	.result (result)
);
